/* hdl/ptb_pkg.sv */
// ----------------------------------------------------------------------------
// ptb_pkg: shared types and constants of the periodic timer bank
// Slot count, time width, operation codes and the queue entry format.
// ----------------------------------------------------------------------------
package ptb_pkg;

  localparam int unsigned TimerSlots = 16;
  localparam int unsigned TimeBits   = 32;
  localparam int unsigned SlotBits   = (TimerSlots > 1) ? $clog2(TimerSlots) : 1;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_CREATE = 3'd1,
    OP_DELETE = 3'd2,
    OP_START  = 3'd3,
    OP_STOP   = 3'd4,
    OP_RESET  = 3'd5,
    OP_BAD6   = 3'd6,
    OP_BAD7   = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OPER
  } bk_state_e;

  // One classified item as it travels from the front part to the back part.
  typedef struct packed {
    op_e                 op;
    logic [3:0]          slot;
    logic                slot_ok;
    logic [TimeBits-1:0] now;
    logic [TimeBits-1:0] fd;
    logic [TimeBits-1:0] per;
    logic                start;
  } cmd_t;

endpackage

/* hdl/ptb_front.sv */
// ----------------------------------------------------------------------------
// ptb_front: input stage and command queue
// Registers incoming items, checks the slot range and queues them.
// ----------------------------------------------------------------------------
module ptb_front
  import ptb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  op_i,
  input  logic [3:0]  slot_i,
  input  logic [31:0] now_ms_i,
  input  logic [31:0] first_delay_ms_i,
  input  logic [31:0] period_ms_i,
  input  logic        start_now_i,
  output logic        cmd_valid_o,
  output cmd_t        cmd_o,
  input  logic        cmd_pop_i
);

  localparam int unsigned PtrBits = $clog2(QueueDepth);

  cmd_t               mem_q [QueueDepth];
  logic [PtrBits-1:0] wr_q, rd_q;
  logic [PtrBits:0]   cnt_q;
  logic               push;
  cmd_t               cmd_in;

  assign in_stall_o  = (cnt_q == (PtrBits+1)'(QueueDepth)) ? 1'b1 : 1'b0;
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = mem_q[rd_q];

  always_comb begin
    cmd_in.op      = op_e'(op_i);
    cmd_in.slot    = slot_i;
    cmd_in.slot_ok = ({28'd0, slot_i} < 32'(TimerSlots));
    cmd_in.now     = TimeBits'(now_ms_i);
    cmd_in.fd      = TimeBits'(first_delay_ms_i);
    cmd_in.per     = TimeBits'(period_ms_i);
    cmd_in.start   = start_now_i;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrBits'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (cmd_pop_i) begin
        rd_q <= (rd_q == PtrBits'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (PtrBits+1)'(push) - (PtrBits+1)'(cmd_pop_i);
    end
  end

endmodule

/* hdl/ptb_back.sv */
// ----------------------------------------------------------------------------
// ptb_back: slot store and sequencer
// Runs one item at a time; ticks scan one slot per cycle unless stalled.
// ----------------------------------------------------------------------------
module ptb_back
  import ptb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  input  cmd_t        cmd_i,
  output logic        cmd_pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [3:0]  slot_id_o,
  output logic        ok_o,
  output logic        last_o
);

  logic [TimerSlots-1:0] in_use_q, en_q, fired_q;
  logic [TimeBits-1:0]   fd_q  [TimerSlots];
  logic [TimeBits-1:0]   per_q [TimerSlots];
  logic [TimeBits-1:0]   due_q [TimerSlots];

  bk_state_e           state_q, state_d;
  logic [SlotBits:0]   idx_q;
  logic [SlotBits-1:0] s;
  // Pending expiry held back until a later one (or end of scan) sets last.
  logic                pend_q;
  logic [3:0]          pend_id_q;

  logic                ov_q, okr_q, kind_q, last_q;
  logic [3:0]          id_q;
  logic                out_free;
  logic                fire;
  logic                scan_end;
  logic                emit;
  logic [SlotBits-1:0] free_idx;
  logic                free_any;
  logic [SlotBits-1:0] tgt;

  assign out_valid_o = ov_q;
  assign kind_o      = kind_q;
  assign slot_id_o   = id_q;
  assign ok_o        = okr_q;
  assign last_o      = last_q;
  assign out_free    = !ov_q || !out_stall_i;

  assign s        = idx_q[SlotBits-1:0];
  assign tgt      = SlotBits'(cmd_i.slot);
  assign scan_end = (idx_q == (SlotBits+1)'(TimerSlots));
  assign fire     = !scan_end && in_use_q[s] && en_q[s]
                    && !(fired_q[s] && per_q[s] == '0) && (due_q[s] <= cmd_i.now);
  // A new result item is loaded into the output register this cycle.
  assign emit     = ((state_q == ST_OPER) && out_free)
                    || ((state_q == ST_SCAN) && pend_q && out_free && (scan_end || fire));

  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = TimerSlots - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        free_idx = SlotBits'(i);
        free_any = 1'b1;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          state_d = (cmd_i.op == OP_TICK) ? ST_SCAN : ST_OPER;
        end
      end
      ST_SCAN: begin
        if (scan_end && (!pend_q || out_free)) begin
          state_d = ST_IDLE;
        end
      end
      ST_OPER: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop_o = 1'b0;
    unique case (state_q)
      ST_SCAN: cmd_pop_o = scan_end && (!pend_q || out_free);
      ST_OPER: cmd_pop_o = out_free;
      default: cmd_pop_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      in_use_q <= '0;
      en_q     <= '0;
      fired_q  <= '0;
      idx_q    <= '0;
      pend_q   <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= emit || (ov_q && out_stall_i);
      unique case (state_q)
        ST_IDLE: begin
          idx_q  <= '0;
          pend_q <= 1'b0;
        end
        ST_SCAN: begin
          if (scan_end) begin
            if (pend_q && out_free) begin
              kind_q <= 1'b0;
              id_q   <= pend_id_q;
              okr_q  <= 1'b1;
              last_q <= 1'b1;
              pend_q <= 1'b0;
            end
          end else if (!fire) begin
            idx_q <= idx_q + 1'b1;
          end else if (!pend_q || out_free) begin
            if (pend_q) begin
              kind_q <= 1'b0;
              id_q   <= pend_id_q;
              okr_q  <= 1'b1;
              last_q <= 1'b0;
            end
            pend_q    <= 1'b1;
            pend_id_q <= 4'(s);
            fired_q[s] <= 1'b1;
            due_q[s]   <= due_q[s] + per_q[s];
            idx_q      <= idx_q + 1'b1;
          end
        end
        ST_OPER: begin
          if (out_free) begin
            kind_q <= 1'b1;
            last_q <= 1'b1;
            if (cmd_i.op == OP_CREATE) begin
              okr_q <= free_any;
              id_q  <= free_any ? 4'(free_idx) : 4'd0;
              if (free_any) begin
                in_use_q[free_idx] <= 1'b1;
                en_q[free_idx]     <= cmd_i.start;
                fired_q[free_idx]  <= 1'b0;
                fd_q[free_idx]     <= cmd_i.fd;
                per_q[free_idx]    <= cmd_i.per;
                due_q[free_idx]    <= cmd_i.now + cmd_i.fd;
              end
            end else begin
              id_q <= cmd_i.slot;
              if (cmd_i.slot_ok && in_use_q[tgt] && cmd_i.op != OP_BAD6
                  && cmd_i.op != OP_BAD7) begin
                okr_q       <= 1'b1;
                fired_q[tgt] <= 1'b0;
                unique case (cmd_i.op)
                  OP_DELETE: begin
                    in_use_q[tgt] <= 1'b0;
                    en_q[tgt]     <= 1'b0;
                  end
                  OP_START: begin
                    en_q[tgt]  <= 1'b1;
                    due_q[tgt] <= cmd_i.now + fd_q[tgt];
                  end
                  OP_STOP: begin
                    en_q[tgt]  <= 1'b0;
                    due_q[tgt] <= cmd_i.now + fd_q[tgt];
                  end
                  default: begin
                    en_q[tgt]  <= cmd_i.start;
                    fd_q[tgt]  <= cmd_i.fd;
                    per_q[tgt] <= cmd_i.per;
                    due_q[tgt] <= cmd_i.now + cmd_i.fd;
                  end
                endcase
              end else begin
                okr_q <= 1'b0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* hdl/periodic_timer_bank_unit.sv */
// ----------------------------------------------------------------------------
// periodic_timer_bank_unit: bank of one-shot and periodic timer slots
// Top level joining the command queue front end and the slot sequencer.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid_i / in_stall_o) carries one item per
// operation: a tick, create, delete, start, stop or reset, each with the
// current time now_ms_i. The output channel (out_valid_o / out_stall_i)
// returns result items: one acknowledge per operation, or one expiry per
// slot that fires on a tick, the final one flagged with last_o.
// Items enter a two-entry queue, so the sender keeps going while the back
// end works. An operation's acknowledge is loaded into the result register
// from the operate state. A tick scans every slot, one per cycle while the
// receiver does not stall, so it occupies the sequencer for the whole bank.
// The scan is the throughput limit for ticks.
// When the receiver stalls, the result register holds and the scan waits
// at the next firing slot; nothing is dropped.
// Reset clears the queue and all in-use, enable and fired flags at once;
// no clearing pass is needed.
module periodic_timer_bank_unit
  import ptb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  op_i,
  input  logic [3:0]  slot_i,
  input  logic [31:0] now_ms_i,
  input  logic [31:0] first_delay_ms_i,
  input  logic [31:0] period_ms_i,
  input  logic        start_now_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [3:0]  slot_id_o,
  output logic        ok_o,
  output logic        last_o
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // Front end: registers items into the queue.
  ptb_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .op_i,
    .slot_i,
    .now_ms_i,
    .first_delay_ms_i,
    .period_ms_i,
    .start_now_i,
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // Back end: owns the slot store and produces every result item.
  ptb_back u_back (
    .clk_i,
    .rst_ni,
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o,
    .out_stall_i,
    .kind_o,
    .slot_id_o,
    .ok_o,
    .last_o
  );

endmodule

/* tb/ptb_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptb_checker: result predictor and scoreboard for the periodic timer bank
// Watches both channels, models the slot bank for each accepted item and
// compares every result item field by field against the oldest expectation.
// ----------------------------------------------------------------------------
module ptb_checker
  import ptb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [2:0]  op_i,
  input  logic [3:0]  slot_i,
  input  logic [31:0] now_ms_i,
  input  logic [31:0] first_delay_ms_i,
  input  logic [31:0] period_ms_i,
  input  logic        start_now_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        kind_i,
  input  logic [3:0]  slot_id_i,
  input  logic        ok_i,
  input  logic        last_i,
  output int          errors_o,
  output int          pending_o
);

  typedef struct packed {
    logic       kind;
    logic [3:0] slot_id;
    logic       ok;
    logic       last;
  } timer_result_t;

  timer_result_t       awaited_results[$];
  logic                slot_used   [TimerSlots];
  logic                slot_armed  [TimerSlots];
  logic                slot_fired  [TimerSlots];
  logic [TimeBits-1:0] slot_delay  [TimerSlots];
  logic [TimeBits-1:0] slot_period [TimerSlots];
  logic [TimeBits-1:0] slot_due    [TimerSlots];

  assign pending_o = awaited_results.size();

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $realtime, what);
    errors_o++;
  endtask

  function automatic timer_result_t make_result(logic k, logic [3:0] id, logic ok, logic l);
    timer_result_t r;
    r.kind = k; r.slot_id = id; r.ok = ok; r.last = l;
    return r;
  endfunction

  task automatic predict_timer_item(input op_e op, input logic [3:0] slot,
                                    input logic [31:0] now, input logic [31:0] fd,
                                    input logic [31:0] per, input logic start);
    int fired;
    int free_slot;
    fired = 0;
    free_slot = -1;
    if (op == OP_TICK) begin
      for (int s = 0; s < TimerSlots; s++) begin
        if (slot_used[s] && slot_armed[s] && !(slot_fired[s] && slot_period[s] == 0)
            && slot_due[s] <= now) begin
          slot_fired[s] = 1'b1;
          slot_due[s]   = slot_due[s] + slot_period[s];
          awaited_results.push_back(make_result(1'b0, s[3:0], 1'b1, 1'b0));
          fired++;
        end
      end
      if (fired > 0) awaited_results[$].last = 1'b1;
    end else if (op == OP_CREATE) begin
      for (int s = TimerSlots - 1; s >= 0; s--) if (!slot_used[s]) free_slot = s;
      if (free_slot < 0) begin
        awaited_results.push_back(make_result(1'b1, 4'd0, 1'b0, 1'b1));
      end else begin
        slot_used[free_slot]   = 1'b1;
        slot_armed[free_slot]  = start;
        slot_delay[free_slot]  = fd;
        slot_period[free_slot] = per;
        slot_due[free_slot]    = now + fd;
        slot_fired[free_slot]  = 1'b0;
        awaited_results.push_back(make_result(1'b1, free_slot[3:0], 1'b1, 1'b1));
      end
    end else if (op inside {OP_BAD6, OP_BAD7} || !slot_used[slot]) begin
      awaited_results.push_back(make_result(1'b1, slot, 1'b0, 1'b1));
    end else begin
      case (op)
        OP_DELETE: begin
          slot_used[slot] = 1'b0; slot_armed[slot] = 1'b0; slot_fired[slot] = 1'b0;
        end
        OP_START: slot_armed[slot] = 1'b1;
        OP_STOP:  slot_armed[slot] = 1'b0;
        default: begin
          slot_armed[slot]  = start;
          slot_delay[slot]  = fd;
          slot_period[slot] = per;
        end
      endcase
      if (op != OP_DELETE) begin
        slot_due[slot]   = now + slot_delay[slot];
        slot_fired[slot] = 1'b0;
      end
      awaited_results.push_back(make_result(1'b1, slot, 1'b1, 1'b1));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    timer_result_t seen, want;
    if (!rst_ni) begin
      awaited_results.delete();
      errors_o = 0;
      for (int s = 0; s < TimerSlots; s++) begin
        slot_used[s] = 1'b0; slot_armed[s] = 1'b0; slot_fired[s] = 1'b0;
        slot_delay[s] = '0; slot_period[s] = '0; slot_due[s] = '0;
      end
    end else begin
      // Results are checked before the new item is modeled; a result can never
      // come out in the same cycle its item is taken in.
      if (out_valid_i && !out_stall_i) begin
        seen = make_result(kind_i, slot_id_i, ok_i, last_i);
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result %p", seen));
        end else begin
          want = awaited_results.pop_front();
          if (seen.kind !== want.kind)
            report_mismatch($sformatf("kind %b, wanted %b", seen.kind, want.kind));
          if (seen.slot_id !== want.slot_id)
            report_mismatch($sformatf("slot_id %0d, wanted %0d", seen.slot_id, want.slot_id));
          if (seen.ok !== want.ok)
            report_mismatch($sformatf("ok %b, wanted %b", seen.ok, want.ok));
          if (seen.last !== want.last)
            report_mismatch($sformatf("last %b, wanted %b", seen.last, want.last));
        end
      end
      if (in_valid_i && !in_stall_i)
        predict_timer_item(op_e'(op_i), slot_i, now_ms_i, first_delay_ms_i, period_ms_i,
                           start_now_i);
    end
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the periodic timer bank
// Drives directed and random timer operations with a running clock value
// through the input channel, stalls the output at random, and lets the
// checker module predict and compare every result item.
// ----------------------------------------------------------------------------
module tb;
  import ptb_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  op_i;
  logic [3:0]  slot_i;
  logic [31:0] now_ms_i;
  logic [31:0] first_delay_ms_i;
  logic [31:0] period_ms_i;
  logic        start_now_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        kind_o;
  logic [3:0]  slot_id_o;
  logic        ok_o;
  logic        last_o;
  int          errors;
  int          pending;

  // Percent of cycles in which the sender idles and the receiver stalls.
  int          send_idle_pct;
  int          recv_stall_pct;

  // The simulated clock value carried with every item; it mostly creeps
  // forward so that periodic slots fire again and again.
  logic [31:0] clock_ms;

  periodic_timer_bank_unit u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .op_i             (op_i),
    .slot_i           (slot_i),
    .now_ms_i         (now_ms_i),
    .first_delay_ms_i (first_delay_ms_i),
    .period_ms_i      (period_ms_i),
    .start_now_i      (start_now_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .slot_id_o        (slot_id_o),
    .ok_o             (ok_o),
    .last_o           (last_o)
  );

  ptb_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .op_i             (op_i),
    .slot_i           (slot_i),
    .now_ms_i         (now_ms_i),
    .first_delay_ms_i (first_delay_ms_i),
    .period_ms_i      (period_ms_i),
    .start_now_i      (start_now_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_i           (kind_o),
    .slot_id_i        (slot_id_o),
    .ok_i             (ok_o),
    .last_i           (last_o),
    .errors_o         (errors),
    .pending_o        (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // The receiver stalls at random, redrawn at every falling edge.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Sends one item: random idle cycles first, then valid held until taken.
  // Valid stays high between back-to-back items, so it is never dropped and
  // raised in the same step.
  task automatic send_timer_item(input op_e op, input logic [3:0] slot,
                                 input logic [31:0] now, input logic [31:0] fd,
                                 input logic [31:0] per, input logic start);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    op_i             <= op;
    slot_i           <= slot;
    now_ms_i         <= now;
    first_delay_ms_i <= fd;
    period_ms_i      <= per;
    start_now_i      <= start;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Small delays and periods make timers fire within a few dozen ticks;
  // now and then a full-width value checks the wide paths.
  function automatic logic [31:0] pick_span();
    case ($urandom_range(9))
      0:       return $urandom();
      1:       return 32'd0;
      default: return $urandom_range(12);
    endcase
  endfunction

  task automatic send_random_item();
    int pick;
    op_e op;
    pick = $urandom_range(99);
    if (pick < 45)      op = OP_TICK;
    else if (pick < 65) op = OP_CREATE;
    else if (pick < 72) op = OP_DELETE;
    else if (pick < 80) op = OP_START;
    else if (pick < 86) op = OP_STOP;
    else if (pick < 96) op = OP_RESET;
    else                op = ($urandom_range(1) != 0) ? OP_BAD7 : OP_BAD6;
    // Time mostly advances by a few ms per tick; rarely it jumps anywhere.
    if ($urandom_range(49) == 0) clock_ms = $urandom();
    else if (op == OP_TICK)      clock_ms = clock_ms + $urandom_range(4);
    send_timer_item(op, 4'($urandom_range(15)), clock_ms, pick_span(), pick_span(),
                    1'($urandom_range(3) != 0));
  endtask

  initial begin
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    out_stall_i      = 1'b0;
    op_i             = OP_TICK;
    slot_i           = '0;
    now_ms_i         = '0;
    first_delay_ms_i = '0;
    period_ms_i      = '0;
    start_now_i      = 1'b0;
    send_idle_pct    = 34;
    recv_stall_pct   = 68;
    clock_ms         = 32'd100;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. Operations on empty slots and unknown codes are refused.
    send_timer_item(OP_TICK,  4'd0,  32'd0, 32'd0, 32'd0, 1'b1);
    send_timer_item(OP_START, 4'd15, 32'd0, 32'd0, 32'd0, 1'b0);
    send_timer_item(OP_BAD6,  4'd3,  32'd0, 32'd0, 32'd0, 1'b0);
    send_timer_item(OP_BAD7,  4'd12, 32'd0, 32'd0, 32'd0, 1'b1);
    // Fill the bank, mixing one-shot, periodic and wide values, then overflow.
    for (int i = 0; i < TimerSlots; i++)
      send_timer_item(OP_CREATE, 4'd0, 32'd100, (i == 1) ? 32'hFFFF_FFFF : i % 4,
                      (i % 3 == 0) ? 32'd0 : 32'hFFFF_FFFF >> (31 - i), 1'b1);
    send_timer_item(OP_CREATE, 4'd0, 32'd100, 32'd1, 32'd1, 1'b1);
    // A tick at the largest time fires every armed slot at once.
    send_timer_item(OP_TICK,   4'd0,  32'hFFFF_FFFF, 32'd0, 32'd0, 1'b0);
    send_timer_item(OP_TICK,   4'd0,  32'hFFFF_FFFF, 32'd0, 32'd0, 1'b0);
    send_timer_item(OP_STOP,   4'd2,  32'd5, 32'd0, 32'd0, 1'b0);
    send_timer_item(OP_RESET,  4'd4,  32'd5, 32'd3, 32'd0, 1'b0);
    send_timer_item(OP_DELETE, 4'd15, 32'd5, 32'd0, 32'd0, 1'b0);
    send_timer_item(OP_CREATE, 4'd0,  32'd5, 32'd0, 32'd2, 1'b0);
    send_timer_item(OP_START,  4'd15, 32'd6, 32'd0, 32'd0, 1'b0);
    send_timer_item(OP_TICK,   4'd0,  32'd20, 32'd0, 32'd0, 1'b0);

    // Random part in three idling phases; start over from an empty-ish bank
    // by deleting everything first so creates succeed again.
    for (int s = 0; s < TimerSlots; s++)
      send_timer_item(OP_DELETE, 4'(s), 32'd0, 32'd0, 32'd0, 1'b0);
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct  = (phase == 0) ? 34 : (phase == 1) ? 68 : 0;
      recv_stall_pct = (phase == 0) ? 68 : (phase == 1) ? 34 : 0;
      repeat (28) send_random_item();
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* files.f */
hdl/ptb_pkg.sv
hdl/ptb_front.sv
hdl/ptb_back.sv
hdl/periodic_timer_bank_unit.sv
tb/ptb_checker.sv
tb/tb.sv
